@@ sv/fdh_pkg.sv @@
`default_nettype none

package fdh_pkg;

   // Packed table key: type, subtype, duration.
   localparam int KEY_W = 22;

   localparam logic [1:0] CONTROL_TYPE = 2'd1;
   localparam logic [3:0] CTS_SUBTYPE  = 4'd12;

   // Result status codes.
   localparam logic [2:0] STATUS_TOSSED  = 3'd0;
   localparam logic [2:0] STATUS_CTS     = 3'd1;
   localparam logic [2:0] STATUS_COUNTED = 3'd2;
   localparam logic [2:0] STATUS_FULL    = 3'd3;
   localparam logic [2:0] STATUS_READ    = 3'd4;

   // Sticky flag bit positions.
   localparam int FLAG_CTS = 0;
   localparam int FLAG_PM  = 1;
   localparam int FLAG_MF  = 2;
   localparam int FLAG_ORD = 3;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_READ  = 4'b0010,
      ST_SCAN  = 4'b0100,
      ST_WRITE = 4'b1000
   } state_type;

endpackage

`default_nettype wire

@@ sv/fdh_ram.sv @@
`default_nettype none

module fdh_ram #(
   parameter int WIDTH = 54,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ sv/frame_duration_histogram_top.sv @@
`default_nettype none

// Frame duration histogram. Each request either processes one parsed frame
// header or reads one slot of the duration table; every request yields
// exactly one result, shown for a single cycle with rsp_strobe high. The
// receiver cannot stall: capture the result in the strobe cycle. Results
// that need no table access (tossed frames, CTS frames, reads of an empty
// slot) arrive in the cycle after the request; a table read passes
// through the READ state first. A counted station frame walks the table
// with one shared key comparator, one slot per cycle through the
// registered read port of the table RAM.
// busy stays high until the result is on the ports. The table is filled in
// order, so a fill count stands in for per-slot valid bits and no clearing
// pass is needed after reset. Write csr_station_address only while idle.
module frame_duration_histogram_top
   import fdh_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64,
   parameter int COUNT_WIDTH   = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [47:0] csr_station_address,
   // request
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_action,
   input  wire logic [1:0]  req_frame_type,
   input  wire logic [3:0]  req_frame_subtype,
   input  wire logic [47:0] req_receiver_address,
   input  wire logic [47:0] req_source_address,
   input  wire logic        req_power_mgmt_bit,
   input  wire logic        req_more_frag_bit,
   input  wire logic        req_order_bit,
   input  wire logic [15:0] req_duration_value,
   input  wire logic [5:0]  req_entry_index,
   // result
   output logic             rsp_strobe,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_tuple_count,
   output logic [31:0]      rsp_total_frames,
   output logic             rsp_cts_seen,
   output logic             rsp_power_mgmt_seen,
   output logic             rsp_more_frag_seen,
   output logic             rsp_order_seen,
   output logic             rsp_entry_valid,
   output logic [1:0]       rsp_entry_type,
   output logic [3:0]       rsp_entry_subtype,
   output logic [15:0]      rsp_entry_duration
);

   localparam int AW     = $clog2(TABLE_ENTRIES);
   localparam int SLOT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int IDX_W  = 6;
   localparam int CMP_W  = (SLOT_W > IDX_W) ? SLOT_W : IDX_W;
   localparam int WORD_W = KEY_W + COUNT_WIDTH;

   // state
   state_type               state_ff, state_in;
   logic [47:0]             stn_ff;
   logic [SLOT_W-1:0]       used_ff, used_in;
   logic [COUNT_WIDTH-1:0]  frames_ff, frames_in;
   logic [3:0]              flags_ff, flags_in;
   logic [KEY_W-1:0]        key_ff, key_in;
   logic [SLOT_W-1:0]       issue_ff, issue_in;
   logic                    pend_ff, pend_in;
   logic [AW-1:0]           pidx_ff, pidx_in;
   logic [AW-1:0]           wr_addr_ff, wr_addr_in;
   logic [COUNT_WIDTH-1:0]  wr_count_ff, wr_count_in;

   // result registers
   logic                    rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]              rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]  rsp_count_ff, rsp_count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]        rsp_key_ff, rsp_key_in;

   // table RAM
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_rd_addr;
   logic [WORD_W-1:0]       ram_rd_data;
   logic [KEY_W-1:0]        rd_key;
   logic [COUNT_WIDTH-1:0]  rd_count;
   logic [COUNT_WIDTH-1:0]  rd_count_inc;
   logic                    key_hit;

   logic [CMP_W-1:0]        idx_ext;
   logic [CMP_W-1:0]        used_ext;
   logic                    accept;

   fdh_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_addr_ff),
      .wr_data ({key_ff, wr_count_ff}),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);

   assign idx_ext  = CMP_W'(req_entry_index);
   assign used_ext = CMP_W'(used_ff);

   assign rd_key       = ram_rd_data[WORD_W-1:COUNT_WIDTH];
   assign rd_count     = ram_rd_data[COUNT_WIDTH-1:0];
   assign rd_count_inc = (rd_count == '1) ? rd_count : rd_count + 1'b1;

   // the shared comparator: key of the slot read last cycle against the frame
   assign key_hit = pend_ff && (rd_key == key_ff);

   // present the requested slot while idle, the next scan slot while scanning
   always_comb begin
      if (state_ff == ST_SCAN) begin
         ram_rd_addr = AW'(issue_ff);
      end else begin
         ram_rd_addr = AW'(idx_ext);
      end
   end

   assign ram_wr_en = (state_ff == ST_WRITE);

   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      frames_in     = frames_ff;
      flags_in      = flags_ff;
      key_in        = key_ff;
      issue_in      = issue_ff;
      pend_in       = pend_ff;
      pidx_in       = pidx_ff;
      wr_addr_in    = wr_addr_ff;
      wr_count_in   = wr_count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_key_in    = rsp_key_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               // default to a tossed request with empty entry fields
               rsp_status_in = STATUS_TOSSED;
               rsp_count_in  = '0;
               rsp_valid_in  = 1'b0;
               rsp_key_in    = '0;
               if (req_action) begin
                  rsp_status_in = STATUS_READ;
                  if (idx_ext < used_ext) begin
                     // RAM captures the slot at this edge
                     state_in = ST_READ;
                  end else begin
                     rsp_strobe_in = 1'b1;
                  end
               end else if (req_frame_type == CONTROL_TYPE) begin
                  rsp_strobe_in = 1'b1;
                  if (req_frame_subtype == CTS_SUBTYPE &&
                      req_receiver_address == stn_ff) begin
                     flags_in[FLAG_CTS] = 1'b1;
                     rsp_status_in      = STATUS_CTS;
                  end
               end else if (req_source_address == stn_ff) begin
                  flags_in[FLAG_PM]  = flags_ff[FLAG_PM]  | req_power_mgmt_bit;
                  flags_in[FLAG_MF]  = flags_ff[FLAG_MF]  | req_more_frag_bit;
                  flags_in[FLAG_ORD] = flags_ff[FLAG_ORD] | req_order_bit;
                  frames_in = (frames_ff == '1) ? frames_ff : frames_ff + 1'b1;
                  key_in    = {req_frame_type, req_frame_subtype, req_duration_value};
                  issue_in  = '0;
                  pend_in   = 1'b0;
                  state_in  = ST_SCAN;
               end else begin
                  rsp_strobe_in = 1'b1;
               end
            end
         end

         ST_READ: begin
            rsp_strobe_in = 1'b1;
            rsp_valid_in  = 1'b1;
            rsp_key_in    = rd_key;
            rsp_count_in  = rd_count;
            state_in      = ST_IDLE;
         end

         ST_SCAN: begin
            if (key_hit) begin
               // match: bump the stored count
               wr_addr_in  = pidx_ff;
               wr_count_in = rd_count_inc;
               state_in    = ST_WRITE;
            end else if (issue_ff != used_ff) begin
               // advance to the next filled slot
               pend_in  = 1'b1;
               pidx_in  = AW'(issue_ff);
               issue_in = issue_ff + 1'b1;
            end else if (used_ff != SLOT_W'(TABLE_ENTRIES)) begin
               // no match: insert in the first free slot
               wr_addr_in  = AW'(used_ff);
               wr_count_in = COUNT_WIDTH'(1);
               used_in     = used_ff + 1'b1;
               state_in    = ST_WRITE;
            end else begin
               // table full: drop the tuple
               rsp_strobe_in = 1'b1;
               rsp_status_in = STATUS_FULL;
               state_in      = ST_IDLE;
            end
         end

         ST_WRITE: begin
            rsp_strobe_in = 1'b1;
            rsp_status_in = STATUS_COUNTED;
            rsp_count_in  = wr_count_ff;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         stn_ff        <= '0;
         used_ff       <= '0;
         frames_ff     <= '0;
         flags_ff      <= '0;
         pend_ff       <= 1'b0;
         issue_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         frames_ff     <= frames_in;
         flags_ff      <= flags_in;
         pend_ff       <= pend_in;
         issue_ff      <= issue_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_valid && csr_ready) begin
            stn_ff <= csr_station_address;
         end
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      pidx_ff       <= pidx_in;
      wr_addr_ff    <= wr_addr_in;
      wr_count_ff   <= wr_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_valid_ff  <= rsp_valid_in;
      rsp_key_ff    <= rsp_key_in;
   end

   // Totals and flags change when a request is accepted and are driven
   // straight from the state registers.
   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_tuple_count     = 32'(rsp_count_ff);
   assign rsp_total_frames    = 32'(frames_ff);
   assign rsp_cts_seen        = flags_ff[FLAG_CTS];
   assign rsp_power_mgmt_seen = flags_ff[FLAG_PM];
   assign rsp_more_frag_seen  = flags_ff[FLAG_MF];
   assign rsp_order_seen      = flags_ff[FLAG_ORD];
   assign rsp_entry_valid     = rsp_valid_ff;
   assign rsp_entry_type      = rsp_key_ff[KEY_W-1:KEY_W-2];
   assign rsp_entry_subtype   = rsp_key_ff[KEY_W-3:KEY_W-6];
   assign rsp_entry_duration  = rsp_key_ff[15:0];

`ifndef NO_ASSERTIONS
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither busy nor answered");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= SLOT_W'(TABLE_ENTRIES))
      else $error("fill count beyond table");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (issue_ff <= used_ff))
      else $error("scan pointer past filled slots");
`endif

endmodule

`default_nettype wire
